>>> rtl/core/kit_pkg.sv
// Shared types and constants for the keyed item table.
// Holds the request/response payloads, the token that walks the cell row,
// and the controller-to-cell command group. No dependencies.
package kit_pkg;

   localparam int TABLE_ENTRIES = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } kit_op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_KEY   = 3'd1,
      ST_NULL_ITEM = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_FULL      = 3'd5
   } kit_status_type;

   typedef enum logic [1:0] {
      KIT_IDLE,
      KIT_WALK,
      KIT_DONE
   } kit_state_type;

   typedef struct packed {
      kit_op_type         req_type;
      logic signed [31:0] lookup_key;
      logic [31:0]        item_handle;
   } kit_req_type;

   typedef struct packed {
      kit_status_type status;
      logic [31:0]    found_item;
      logic [4:0]     entry_total;
   } kit_rsp_type;

   // Search token handed from cell to cell, one cell per cycle.
   typedef struct packed {
      logic        active;
      kit_op_type  op;
      logic [30:0] key;
      logic [31:0] item;
      logic        hit;
      logic        free_seen;
   } kit_token_type;

   // Broadcast from the controller to every cell when an item finishes.
   typedef struct packed {
      logic clear;
      logic commit;
      logic finish;
   } kit_cmd_type;

endpackage

>>> rtl/core/kit_cell.sv
// One table slot of the keyed item table: valid bit, key and item.
// Compares the passing token against its slot and hands it to the next cell.
// Depends on kit_pkg.
module kit_cell
   import kit_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  kit_token_type prev_tok,
   input  kit_cmd_type   cmd,
   output kit_token_type next_tok
);

   logic          valid_ff, valid_in;
   logic          claim_ff, claim_in;
   logic [30:0]   key_ff, key_in;
   logic [31:0]   item_ff, item_in;
   kit_token_type pass_ff, pass_in;
   logic          match;
   logic          take;

   always_comb begin
      match = valid_ff && (key_ff == prev_tok.key);
      // The first free slot an insert passes is reserved; it becomes valid
      // only if the whole walk finds no duplicate.
      take  = prev_tok.active && (prev_tok.op == OP_INSERT) && !valid_ff &&
              !prev_tok.free_seen;

      pass_in           = prev_tok;
      pass_in.hit       = prev_tok.hit || match;
      pass_in.free_seen = prev_tok.free_seen || !valid_ff;
      if (match) begin
         pass_in.item = item_ff;
      end

      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.commit && claim_ff) begin
         valid_in = 1'b1;
      end else if (prev_tok.active && (prev_tok.op == OP_REMOVE) && match) begin
         valid_in = 1'b0;
      end

      claim_in = claim_ff;
      if (cmd.finish) begin
         claim_in = 1'b0;
      end else if (take) begin
         claim_in = 1'b1;
      end

      key_in  = take ? prev_tok.key : key_ff;
      item_in = take ? prev_tok.item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         claim_ff       <= 1'b0;
         pass_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         claim_ff <= claim_in;
         pass_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      item_ff <= item_in;
   end

   assign next_tok = pass_ff;

endmodule

>>> rtl/core/kit_ctrl.sv
// Request controller of the keyed item table: decodes items, launches the
// search token, collects it from the last cell and drives the response register.
// Depends on kit_pkg.
module kit_ctrl
   import kit_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  kit_req_type   req_item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output kit_rsp_type   rsp_item,
   output kit_token_type launch_tok,
   input  kit_token_type tail_tok,
   output kit_cmd_type   cmd
);

   kit_state_type  state_ff, state_in;
   kit_op_type     op_ff, op_in;
   kit_status_type status_ff, status_in;
   logic [31:0]    found_ff, found_in;
   logic [4:0]     count_ff, count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   kit_rsp_type    rsp_item_ff, rsp_item_in;
   logic           accept;
   logic           need_walk;
   logic           load;
   kit_status_type quick_status;

   // Decode of the incoming item: what can be answered without a walk.
   always_comb begin
      accept       = req_valid && req_ready;
      need_walk    = 1'b0;
      quick_status = ST_OK;
      if (req_item.req_type == OP_CLEAR) begin
         quick_status = ST_OK;
      end else if (req_item.lookup_key[31]) begin
         quick_status = ST_BAD_KEY;
      end else if ((req_item.req_type == OP_INSERT) && (req_item.item_handle == 32'd0)) begin
         quick_status = ST_NULL_ITEM;
      end else begin
         need_walk = 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         KIT_IDLE: begin
            if (accept) begin
               state_in = need_walk ? KIT_WALK : KIT_DONE;
            end
         end
         KIT_WALK: begin
            if (tail_tok.active) begin
               state_in = KIT_DONE;
            end
         end
         KIT_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = KIT_IDLE;
            end
         end
         default: state_in = KIT_IDLE;
      endcase
   end

   // Outputs and data path updates.
   always_comb begin
      req_ready = (state_ff == KIT_IDLE);
      load      = (state_ff == KIT_DONE) && (!rsp_valid_ff || rsp_ready);

      cmd.finish = load;
      cmd.clear  = load && (op_ff == OP_CLEAR);
      cmd.commit = load && (op_ff == OP_INSERT) && (status_ff == ST_OK);

      launch_tok.active    = accept && need_walk;
      launch_tok.op        = req_item.req_type;
      launch_tok.key       = req_item.lookup_key[30:0];
      launch_tok.item      = req_item.item_handle;
      launch_tok.hit       = 1'b0;
      launch_tok.free_seen = 1'b0;

      op_in     = op_ff;
      status_in = status_ff;
      found_in  = found_ff;
      if (accept) begin
         op_in     = req_item.req_type;
         status_in = quick_status;
         found_in  = 32'd0;
      end else if ((state_ff == KIT_WALK) && tail_tok.active) begin
         found_in = 32'd0;
         if (op_ff == OP_INSERT) begin
            if (tail_tok.hit) begin
               status_in = ST_DUPLICATE;
            end else if (!tail_tok.free_seen) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_OK;
            end
         end else if (tail_tok.hit) begin
            status_in = ST_OK;
            found_in  = tail_tok.item;
         end else begin
            status_in = ST_NOT_FOUND;
         end
      end

      count_in = count_ff;
      if (load) begin
         if (op_ff == OP_CLEAR) begin
            count_in = 5'd0;
         end else if ((op_ff == OP_INSERT) && (status_ff == ST_OK)) begin
            count_in = count_ff + 5'd1;
         end else if ((op_ff == OP_REMOVE) && (status_ff == ST_OK)) begin
            count_in = count_ff - 5'd1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_item_in.status      = status_ff;
         rsp_item_in.found_item  = found_ff;
         rsp_item_in.entry_total = count_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= KIT_IDLE;
         count_ff     <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> rtl/core/keyed_item_table.sv
// Top level of the keyed item table: controller plus a row of slot cells.
// Depends on kit_pkg, kit_cell and kit_ctrl.
//
// Associative table of TABLE_ENTRIES slots mapping non-negative 31-bit keys
// to nonzero 32-bit items. Insert, find and remove send a search token down
// the row of cells, one cell per cycle; the response is registered once the
// token leaves the last cell. Clear and items rejected up front (negative
// key, null item on insert) skip the walk. One item is worked on at a time;
// a finished response sits in an output register, so the next item can be
// accepted while the response waits to be taken.
module keyed_item_table
   import kit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  kit_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output kit_rsp_type rsp_item
);

   kit_token_type tok_link [TABLE_ENTRIES + 1];
   kit_cmd_type   cmd;

   kit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item),
      .launch_tok (tok_link[0]),
      .tail_tok   (tok_link[TABLE_ENTRIES]),
      .cmd        (cmd)
   );

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      kit_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .prev_tok (tok_link[i]),
         .cmd      (cmd),
         .next_tok (tok_link[i + 1])
      );
   end

endmodule

>>> rtl/core/kit_checker.sv
// Port-level checks for the keyed item table, bound to the top level.
// Depends on kit_pkg and keyed_item_table.
module kit_checker
   import kit_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input kit_rsp_type rsp_item
);

   // A response that is not taken holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("response changed while stalled");

   // Only a successful find or remove returns an item.
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != ST_OK) |-> rsp_item.found_item == 32'd0)
      else $error("failed request returned an item");

   // Unless an earlier response is still held, no response may appear in the cycle right after an item is accepted.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (!rsp_valid || rsp_ready) |=> !rsp_valid)
      else $error("response appeared too early");

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind keyed_item_table kit_checker u_kit_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
